>>> rtl/core/tbdal_pkg.sv
// Shared types and constants of the three-button debounced action latch.
package tbdal_pkg;

  localparam int unsigned NUM_BTN   = 3;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned THR_W     = 16;

  // Register map of the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UD_POL   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EN_POL   = 8'd3;

  localparam logic [THR_W-1:0] DEBOUNCE_RST = 16'd35;
  localparam logic [THR_W-1:0] TIMEOUT_RST  = 16'd1500;
  localparam logic             UD_POL_RST   = 1'b0;
  localparam logic             EN_POL_RST   = 1'b1;

  // Button slots in poll order
  localparam int unsigned BTN_UP    = 0;
  localparam int unsigned BTN_DOWN  = 1;
  localparam int unsigned BTN_ENTER = 2;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_UP    = 2'd1,
    ACT_DOWN  = 2'd2,
    ACT_ENTER = 2'd3
  } action_e;

endpackage

>>> rtl/core/tbdal_ifs.sv
// Channel interfaces: button tick input, action result output, register writes.
interface tbdal_btn_if;
  logic valid;
  logic ready;
  logic up_level;
  logic down_level;
  logic enter_level;
  logic clear_request;

  modport source (output valid, up_level, down_level, enter_level, clear_request,
                  input ready);
  modport sink   (input valid, up_level, down_level, enter_level, clear_request,
                  output ready);
endinterface

interface tbdal_act_if;
  logic       valid;
  logic       ready;
  logic [1:0] pending_action;

  modport source (output valid, pending_action, input ready);
  modport sink   (input valid, pending_action, output ready);
endinterface

interface tbdal_cfg_if import tbdal_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/three_button_debounced_action_latch.sv
// Top level: debounced three-button action latch with tick input and action output.
//
// Usage:
//   btn_i carries one tick per beat: raw up/down/enter levels and a clear
//   request. act_o returns one beat per tick with the action slot contents
//   after that tick (none, up, down, enter). cfg_i writes the debounce and
//   timeout thresholds and the two polarity bits; it is always ready and
//   should only be written while no tick is in flight.
//   A tick is captured in the input register, then evaluated into the
//   slot register, which doubles as the result register. Throughput:
//   one tick per cycle while act_o is ready, set by the single state-update
//   pass (four parallel age compares feeding a three-button priority chain).
//   Reset clears the tick counter, all button marks (levels read as
//   released), the action slot and restores the register defaults.
//   When the receiver stalls, the pending result holds on act_o, the tick
//   in the input register waits, and btn_i drops ready once that register
//   is full; no beat is lost or repeated.
module three_button_debounced_action_latch import tbdal_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tbdal_btn_if.sink     btn_i,
  tbdal_act_if.source   act_o,
  tbdal_cfg_if.sink     cfg_i
);

  // Configuration registers
  logic [THR_W-1:0] debounce_q;
  logic [THR_W-1:0] timeout_q;
  logic             ud_hi_q;
  logic             en_hi_q;

  // Input register stage
  logic in_vld_q;
  logic up_q, dn_q, en_q, clr_q;

  // Result stage handshake
  logic out_vld_q;
  logic advance;

  // Tick state
  logic [TIME_BITS-1:0] tick_q;
  logic [TIME_BITS-1:0] stamp_q [NUM_BTN];
  logic [TIME_BITS-1:0] stamp_d [NUM_BTN];
  logic [NUM_BTN-1:0]   sv_q, sv_d;
  logic [NUM_BTN-1:0]   last_q, last_d;
  logic [NUM_BTN-1:0]   primed_q, primed_d;
  logic [NUM_BTN-1:0]   emitted_q, emitted_d;
  action_e              slot_q, slot_d;
  logic [TIME_BITS-1:0] slot_stamp_q, slot_stamp_d;

  // Evaluation signals
  logic [NUM_BTN-1:0]   pressed;
  logic [NUM_BTN-1:0]   press_edge;
  logic [NUM_BTN-1:0]   fire;
  logic [NUM_BTN-1:0]   emitted_base;
  logic [TIME_BITS-1:0] btn_age [NUM_BTN];
  logic [TIME_BITS-1:0] slot_age;
  action_e              slot_clr;
  logic                 slot_full;
  logic                 expired;
  logic                 poll;
  logic                 slot_empty;

  // ---------------------------------------------------------------
  // Configuration writes: index beyond the map is dropped
  // ---------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      timeout_q  <= TIMEOUT_RST;
      ud_hi_q    <= UD_POL_RST;
      en_hi_q    <= EN_POL_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_DEBOUNCE: debounce_q <= cfg_i.data[THR_W-1:0];
        CFG_TIMEOUT:  timeout_q  <= cfg_i.data[THR_W-1:0];
        CFG_UD_POL:   ud_hi_q    <= cfg_i.data[0];
        CFG_EN_POL:   en_hi_q    <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Handshake: evaluate a held tick whenever the result stage is free
  // ---------------------------------------------------------------
  assign advance     = in_vld_q && (!out_vld_q || act_o.ready);
  assign btn_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (btn_i.ready) begin
        in_vld_q <= btn_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (act_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload of the input register needs no reset
  always_ff @(posedge clk_i) begin
    if (btn_i.ready && btn_i.valid) begin
      up_q  <= btn_i.up_level;
      dn_q  <= btn_i.down_level;
      en_q  <= btn_i.enter_level;
      clr_q <= btn_i.clear_request;
    end
  end

  // ---------------------------------------------------------------
  // Tick evaluation
  // ---------------------------------------------------------------
  assign pressed[BTN_UP]    = (up_q == ud_hi_q);
  assign pressed[BTN_DOWN]  = (dn_q == ud_hi_q);
  assign pressed[BTN_ENTER] = (en_q == en_hi_q);

  // Clear request first, then the timeout check on whatever is left
  assign slot_clr  = clr_q ? ACT_NONE : slot_q;
  assign slot_full = (slot_clr != ACT_NONE);
  assign slot_age  = tick_q - slot_stamp_q;
  assign expired   = (slot_age >= TIME_BITS'(timeout_q));
  assign poll      = !slot_full || expired;

  // An expired slot drops and re-arms every button in the same tick
  assign emitted_base = (slot_full && expired) ? '0 : emitted_q;

  always_comb begin
    // While polling the slot is always empty at the start of the chain
    slot_empty = 1'b1;
    for (int i = 0; i < NUM_BTN; i++) begin
      press_edge[i] = pressed[i] && !last_q[i];
      // A fresh edge stamps now, so its age is zero
      btn_age[i]    = press_edge[i] ? '0 : (tick_q - stamp_q[i]);
      fire[i]       = poll && pressed[i] && primed_q[i] && !emitted_base[i] &&
                      slot_empty && (press_edge[i] || sv_q[i]) &&
                      (btn_age[i] >= TIME_BITS'(debounce_q));
      slot_empty    = slot_empty && !fire[i];

      if (poll) begin
        stamp_d[i]   = press_edge[i] ? tick_q : stamp_q[i];
        sv_d[i]      = pressed[i] && (press_edge[i] || sv_q[i]);
        last_d[i]    = pressed[i];
        primed_d[i]  = primed_q[i] || !pressed[i];
        emitted_d[i] = pressed[i] && (emitted_base[i] || fire[i]);
      end else begin
        stamp_d[i]   = stamp_q[i];
        sv_d[i]      = sv_q[i];
        last_d[i]    = last_q[i];
        primed_d[i]  = primed_q[i];
        emitted_d[i] = emitted_base[i];
      end
    end

    // Priority up, down, enter (at most one fires thanks to the chain)
    if (!poll) begin
      slot_d = slot_clr;
    end else if (fire[BTN_UP]) begin
      slot_d = ACT_UP;
    end else if (fire[BTN_DOWN]) begin
      slot_d = ACT_DOWN;
    end else if (fire[BTN_ENTER]) begin
      slot_d = ACT_ENTER;
    end else begin
      slot_d = ACT_NONE;
    end
    slot_stamp_d = (|fire) ? tick_q : slot_stamp_q;
  end

  // ---------------------------------------------------------------
  // State update: one tick per advance
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= '0;
      sv_q         <= '0;
      last_q       <= '0;
      primed_q     <= '0;
      emitted_q    <= '0;
      slot_q       <= ACT_NONE;
      slot_stamp_q <= '0;
      for (int i = 0; i < NUM_BTN; i++) begin
        stamp_q[i] <= '0;
      end
    end else if (advance) begin
      tick_q       <= tick_q + TIME_BITS'(1);
      sv_q         <= sv_d;
      last_q       <= last_d;
      primed_q     <= primed_d;
      emitted_q    <= emitted_d;
      slot_q       <= slot_d;
      slot_stamp_q <= slot_stamp_d;
      for (int i = 0; i < NUM_BTN; i++) begin
        stamp_q[i] <= stamp_d[i];
      end
    end
  end

  // The slot only moves on advance, and advance needs a free result
  // stage, so the slot register doubles as the result register.
  assign act_o.valid          = out_vld_q;
  assign act_o.pending_action = slot_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_fire_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |-> $onehot0(fire))
    else $error("more than one button fired in one tick");

  a_tick_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(tick_q) && $stable(slot_q))
    else $error("tick state moved without an evaluated tick");

  a_fire_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (|fire) |=> (slot_stamp_q == $past(tick_q)) && (slot_q != ACT_NONE))
    else $error("fired action not latched with its tick stamp");

  a_fire_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (|fire) |=> (emitted_q & $past(fire)) == $past(fire))
    else $error("fired button left without its emitted mark");

endmodule

>>> verif/three_button_debounced_action_latch_tb.sv
// Self-checking testbench for the three-button debounced action latch.
`timescale 1ns / 1ps

module three_button_debounced_action_latch_tb;
  import tbdal_pkg::*;

  // Worst case is about 1700 ticks, each waiting out the longest sender gap
  // and the longest receiver stall, plus the long hold and the drains.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_HOLD_CYCLES = 150;
  localparam int unsigned PHASE_TICKS = 215;
  localparam int unsigned NUM_PHASES = 8;
  // An index past the register map: the block must ignore the write.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd77;

  // Predicts the action slot tick by tick and checks each returned beat.
  class action_tracker;
    logic [THR_W-1:0] debounce_len;
    logic [THR_W-1:0] timeout_len;
    logic             ud_pol;
    logic             en_pol;
    logic [31:0]      tick_now;
    logic [31:0]      press_at[NUM_BTN];
    bit               stamp_ok[NUM_BTN];
    bit               was_pressed[NUM_BTN];
    bit               primed[NUM_BTN];
    bit               emitted[NUM_BTN];
    action_e          slot;
    logic [31:0]      slot_at;
    action_e          expected_actions[$];
    int               mismatches;
    int               checked;
    int               latched[NUM_BTN];

    function new();
      debounce_len = DEBOUNCE_RST;
      timeout_len  = TIMEOUT_RST;
      ud_pol       = UD_POL_RST;
      en_pol       = EN_POL_RST;
      tick_now     = '0;
      slot         = ACT_NONE;
      slot_at      = '0;
      mismatches   = 0;
      checked      = 0;
      for (int b = 0; b < NUM_BTN; b++) begin
        press_at[b]    = '0;
        stamp_ok[b]    = 1'b0;
        was_pressed[b] = 1'b0;
        primed[b]      = 1'b0;
        emitted[b]     = 1'b0;
        latched[b]     = 0;
      end
    endfunction

    task report(input string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatches++;
    endtask

    function void apply_write(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_DEBOUNCE: debounce_len = data;
        CFG_TIMEOUT:  timeout_len  = data;
        CFG_UD_POL:   ud_pol       = data[0];
        CFG_EN_POL:   en_pol       = data[0];
        default: ;
      endcase
    endfunction

    function void note_tick(input logic up_lv, input logic dn_lv, input logic en_lv,
                            input logic clr);
      bit          pressed[NUM_BTN];
      action_e     code_of[NUM_BTN];
      bit          poll;
      logic [31:0] age;
      pressed[BTN_UP]    = (up_lv == ud_pol);
      pressed[BTN_DOWN]  = (dn_lv == ud_pol);
      pressed[BTN_ENTER] = (en_lv == en_pol);
      code_of[BTN_UP]    = ACT_UP;
      code_of[BTN_DOWN]  = ACT_DOWN;
      code_of[BTN_ENTER] = ACT_ENTER;
      poll = 1'b1;
      if (clr) slot = ACT_NONE;
      // An unclaimed action blocks polling until it ages out.
      if (slot != ACT_NONE) begin
        age = tick_now - slot_at;
        if (age >= timeout_len) begin
          slot = ACT_NONE;
          for (int b = 0; b < NUM_BTN; b++) emitted[b] = 1'b0;
        end else begin
          poll = 1'b0;
        end
      end
      if (poll) begin
        for (int b = 0; b < NUM_BTN; b++) begin
          if (pressed[b]) begin
            if (!was_pressed[b]) begin
              press_at[b] = tick_now;
              stamp_ok[b] = 1'b1;
            end
            age = tick_now - press_at[b];
            if (primed[b] && !emitted[b] && slot == ACT_NONE && stamp_ok[b] &&
                age >= debounce_len) begin
              slot       = code_of[b];
              slot_at    = tick_now;
              emitted[b] = 1'b1;
              latched[b]++;
            end
          end else begin
            stamp_ok[b] = 1'b0;
            press_at[b] = '0;
            emitted[b]  = 1'b0;
            primed[b]   = 1'b1;
          end
          was_pressed[b] = pressed[b];
        end
      end
      expected_actions.push_back(slot);
      tick_now = tick_now + 1;
    endfunction

    task check_action(input logic [1:0] got);
      action_e want;
      if (expected_actions.size() == 0) begin
        report($sformatf("action beat %0d with no tick outstanding", got));
      end else begin
        want = expected_actions.pop_front();
        checked++;
        if (got !== want)
          report($sformatf("beat %0d: pending_action %0d, want %s",
                           checked, got, want.name()));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  tbdal_btn_if btn_ch();
  tbdal_act_if act_ch();
  tbdal_cfg_if cfg_ch();

  three_button_debounced_action_latch dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .btn_i  (btn_ch),
    .act_o  (act_ch),
    .cfg_i  (cfg_ch)
  );

  action_tracker sb = new();

  int unsigned cycle_count = 0;
  int          ticks_sent = 0;
  int          clears_sent = 0;
  int          settings_used = 1;
  bit          calm = 1'b0;       // no idling on either side
  bit          sink_hold = 1'b0;  // long receiver stall in progress
  bit          hold_request = 1'b0;

  // Clock: 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.expected_actions.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Sample every handshake at the rising edge. Register writes and ticks never
  // share an edge, and a tick's result never comes out on its own input edge,
  // so the order inside this block does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.apply_write(cfg_ch.index, cfg_ch.data);
      if (act_ch.valid && act_ch.ready) sb.check_action(act_ch.pending_action);
      if (btn_ch.valid && btn_ch.ready)
        sb.note_tick(btn_ch.up_level, btn_ch.down_level, btn_ch.enter_level,
                     btn_ch.clear_request);
    end
  end

  // Receiver: drop ready in random bursts, with quiet stretches in
  // between, and hold it low during the long stall.
  initial begin : result_ready_drive
    int burst;
    int quiet;
    burst = 0;
    quiet = 0;
    act_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (burst > 0) begin
        burst--;
      end else if (quiet > 0) begin
        quiet--;
      end else if (!calm) begin
        case ($urandom_range(0, 19))
          0, 1, 2: burst = $urandom_range(1, 15);
          3:       quiet = $urandom_range(40, 120);
          default: ;
        endcase
      end
      act_ch.ready <= !(sink_hold || (burst > 0 && !calm));
    end
  end

  // Long receiver stall, counted in cycles here; the sender keeps offering
  // ticks meanwhile so the block fills and must back-pressure its input.
  initial begin : long_result_stall
    wait (hold_request);
    @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  // Offer one tick with raw levels; return at the falling edge after the beat.
  task automatic send_tick(input logic up_lv, input logic dn_lv, input logic en_lv,
                           input logic clr);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      btn_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    btn_ch.valid         <= 1'b1;
    btn_ch.up_level      <= up_lv;
    btn_ch.down_level    <= dn_lv;
    btn_ch.enter_level   <= en_lv;
    btn_ch.clear_request <= clr;
    @(posedge clk_i);
    while (!btn_ch.ready) @(posedge clk_i);
    ticks_sent++;
    if (clr) clears_sent++;
    @(negedge clk_i);
  endtask

  // Offer a tick by pressed mask {enter, down, up}, translated through the
  // polarity currently programmed.
  task automatic send_press(input logic [2:0] pressed, input logic clr);
    send_tick(pressed[BTN_UP] ? sb.ud_pol : !sb.ud_pol,
              pressed[BTN_DOWN] ? sb.ud_pol : !sb.ud_pol,
              pressed[BTN_ENTER] ? sb.en_pol : !sb.en_pol, clr);
  endtask

  // Write one register; start and end on a falling edge with valid low.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop offering ticks and wait until every expected action has come back.
  task automatic drain();
    btn_ch.valid <= 1'b0;
    while (sb.expected_actions.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_all(input logic [15:0] deb, input logic [15:0] tmo,
                             input logic ud, input logic en);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_UD_POL, {15'h0, ud});
    write_reg(CFG_EN_POL, {15'h0, en});
    settings_used++;
  endtask

  // Mostly clean press episodes: a short release, then a held press of
  // random length up to debounce plus timeout plus four, capped at 80. Some
  // holds bounce, some ticks carry a clear, and a few bursts are pure noise.
  task automatic run_episodes(input int n_ticks);
    int         first;
    int         rel;
    int         hold;
    int         lim;
    logic [2:0] mask;
    first = ticks_sent;
    while (ticks_sent - first < n_ticks) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_tick($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                    $urandom_range(0, 1) == 1, $urandom_range(0, 7) == 0);
      end else begin
        mask = 3'b001 << $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) mask = mask | 3'($urandom_range(1, 7));
        lim = int'(sb.debounce_len) + int'(sb.timeout_len) + 4;
        if (lim > 80) lim = 80;
        rel  = $urandom_range(1, 4);
        hold = $urandom_range(1, lim);
        repeat (rel) send_press(3'b000, $urandom_range(0, 11) == 0);
        repeat (hold) begin
          if ($urandom_range(0, 15) == 0) mask = mask ^ (3'b001 << $urandom_range(0, 2));
          send_press(mask, $urandom_range(0, 11) == 0);
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] deb;
    logic [15:0] tmo;
    int          n;
    btn_ch.valid         = 1'b0;
    btn_ch.up_level      = 1'b0;
    btn_ch.down_level    = 1'b0;
    btn_ch.enter_level   = 1'b0;
    btn_ch.clear_request = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    rst_ni               = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset defaults: buttons held through reset get stamped on the first
    // tick but must not fire until released once.
    repeat (3) send_press(3'b111, 1'b0);
    repeat (2) send_press(3'b000, 1'b0);
    send_press(3'b001, 1'b1);
    drain();

    // Register bits: a polarity write keeps only bit 0, and a write past
    // the register map does nothing.
    write_reg(CFG_UD_POL, 16'hFFFE);
    write_reg(CFG_IDX_SPARE, 16'hFFFF);
    // Zero debounce fires on the press edge; zero timeout drops the action
    // at the next tick and polls again in that tick.
    program_all(16'd0, 16'd0, 1'b1, 1'b0);
    send_press(3'b111, 1'b0);
    send_press(3'b111, 1'b0);
    send_press(3'b110, 1'b0);
    send_press(3'b100, 1'b0);
    send_press(3'b100, 1'b1);
    send_press(3'b000, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    drain();

    // Largest debounce: nothing can fire in a short hold.
    program_all(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    send_press(3'b000, 1'b0);
    repeat (3) send_press(3'b001, 1'b0);
    drain();

    // Largest timeout: an action stays put and blocks polling until cleared.
    program_all(16'd2, 16'hFFFF, 1'b0, 1'b1);
    repeat (4) send_press(3'b001, 1'b0);
    repeat (2) send_press(3'b010, 1'b0);
    send_press(3'b010, 1'b1);
    repeat (2) send_press(3'b100, 1'b0);
    drain();

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin deb = 16'd0;     tmo = 16'd0;     end
        1:       begin deb = 16'hFFFF;  tmo = 16'hFFFF;  end
        2:       begin deb = 16'd0;     tmo = 16'hFFFF;  end
        default: begin deb = 16'($urandom_range(0, 6)); tmo = 16'($urandom_range(0, 30)); end
      endcase
      program_all(deb, tmo, $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
      n = (p == 1) ? 60 : PHASE_TICKS;
      if (p == NUM_PHASES - 1) calm = 1'b1;
      if (p == 3) begin
        run_episodes(n / 3);
        hold_request = 1'b1;
        run_episodes(n - n / 3);
      end else if (p == 5) begin
        run_episodes(n / 2);
        drain();
        run_episodes(n - n / 2);
      end else begin
        run_episodes(n);
      end
      drain();
    end

    if (sb.expected_actions.size() != 0)
      sb.report($sformatf("%0d actions never returned", sb.expected_actions.size()));
    $display("Covered %0d ticks (%0d with clear) under %0d register settings; %0d beats checked.",
             ticks_sent, clears_sent, settings_used, sb.checked);
    $display("Latched actions: up %0d, down %0d, enter %0d.",
             sb.latched[BTN_UP], sb.latched[BTN_DOWN], sb.latched[BTN_ENTER]);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
